@@ hw/rtl/tsp_pkg.sv @@
// Shared types and constants for the ttl slot pool.
// Used by tsp_ctrl, tsp_datapath and the top level.
package tsp_pkg;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;

  localparam logic [7:0] TTL_START = 8'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] owner_key;
    logic signed [31:0] primary_value;
    logic signed [31:0] secondary_value;
    logic [7:0]         label_first_byte;
  } tsp_req_t;

  typedef struct packed {
    logic [5:0]         slot_index;
    logic               pool_full;
    logic signed [31:0] primary_sum;
    logic signed [31:0] secondary_sum;
  } tsp_rsp_t;

  typedef struct packed {
    logic [7:0]  ttl;
    logic [31:0] owner;
    logic [31:0] primary;
    logic [31:0] secondary;
    logic [7:0]  label;
  } tsp_slot_t;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan;
    logic load;
  } tsp_ctrl_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
  } tsp_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tsp_state_e;

endpackage

@@ hw/rtl/tsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tsp_ctrl.sv @@
// Sequencer for the slot pool: clearing pass, request accept, scan, result.
// Depends on tsp_pkg.
module tsp_ctrl import tsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  tsp_status_t status_i,
  output tsp_ctrl_t   ctrl_o
);

  tsp_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       rsp_free;

  assign rsp_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (status_i.scan_done) state_d = ST_DONE;
      ST_DONE:  if (rsp_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    in_stall_o   = 1'b1;
    ctrl_o.clear = (state_q == ST_CLEAR);
    ctrl_o.scan  = (state_q == ST_SCAN);
    ctrl_o.load  = (state_q == ST_DONE) && rsp_free;
    if (state_q == ST_IDLE) begin
      in_stall_o   = 1'b0;
      ctrl_o.start = in_valid_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/tsp_datapath.sv @@
// Slot memory, scan counter, accumulators and result register.
// Depends on tsp_pkg and tsp_ram.
module tsp_datapath import tsp_pkg::*; #(
  parameter int SlotCount = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tsp_ctrl_t   ctrl_i,
  output tsp_status_t status_o,
  input  tsp_req_t    in_req_i,
  output tsp_rsp_t    out_rsp_o
);

  localparam int AW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int CW = $clog2(SlotCount + 1);
  localparam logic [CW-1:0] CntEnd = CW'(SlotCount);

  tsp_req_t    req_q;
  tsp_rsp_t    rsp_q;
  logic [CW-1:0] cnt_q;
  logic        rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic        found_q;
  logic [AW-1:0] found_idx_q;
  logic [31:0] psum_q, ssum_q;

  logic        we, issue, empty, owner_hit, cnt_busy;
  logic [AW-1:0] waddr;
  tsp_slot_t   wslot, rslot;
  logic [7:0]  ttl_aged;

  assign cnt_busy  = (cnt_q != CntEnd);
  assign issue     = ctrl_i.scan && cnt_busy && !found_q;
  assign empty     = (rslot.primary == '0) && (rslot.secondary == '0) && (rslot.label == '0);
  assign owner_hit = (rslot.owner == req_q.owner_key);
  assign ttl_aged  = rslot.ttl - 8'd1;

  always_comb begin
    we    = 1'b0;
    waddr = rd_idx_q;
    wslot = rslot;
    if (ctrl_i.clear) begin
      we    = cnt_busy;
      waddr = cnt_q[AW-1:0];
      wslot = '0;
    end else if (ctrl_i.scan && rd_vld_q) begin
      case (req_q.cmd)
        CMD_REGISTER: begin
          if (!found_q && empty) begin
            we              = 1'b1;
            wslot.ttl       = TTL_START;
            wslot.owner     = req_q.owner_key;
            wslot.primary   = req_q.primary_value;
            wslot.secondary = req_q.secondary_value;
            wslot.label     = req_q.label_first_byte;
          end
        end
        CMD_TICK: begin
          we        = 1'b1;
          wslot.ttl = ttl_aged;
          // signed ttl at or below zero expires the slot; owner is kept
          if (ttl_aged == 8'd0 || ttl_aged[7]) begin
            wslot.primary   = '0;
            wslot.secondary = '0;
            wslot.label     = '0;
          end
        end
        default: we = 1'b0;
      endcase
    end
  end

  tsp_ram #(
    .Width($bits(tsp_slot_t)),
    .Depth(SlotCount)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wslot),
    .re_i   (issue),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(rslot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (ctrl_i.start) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      if (cnt_busy) cnt_q <= cnt_q + CW'(1);
    end else if (ctrl_i.scan) begin
      rd_vld_q <= issue;
      if (issue) cnt_q <= cnt_q + CW'(1);
      if (rd_vld_q && req_q.cmd == CMD_REGISTER && !found_q && empty) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      req_q  <= in_req_i;
      psum_q <= '0;
      ssum_q <= '0;
    end else if (ctrl_i.scan) begin
      if (issue) rd_idx_q <= cnt_q[AW-1:0];
      if (rd_vld_q && req_q.cmd == CMD_REGISTER && !found_q && empty) begin
        found_idx_q <= rd_idx_q;
      end
      // zero values add nothing, so no nonzero test is needed
      if (rd_vld_q && req_q.cmd == CMD_QUERY && owner_hit) begin
        psum_q <= psum_q + rslot.primary;
        ssum_q <= ssum_q + rslot.secondary;
      end
    end
    if (ctrl_i.load) begin
      rsp_q.slot_index    <= found_q ? 6'(found_idx_q) : 6'd0;
      rsp_q.pool_full     <= (req_q.cmd == CMD_REGISTER) && !found_q;
      rsp_q.primary_sum   <= psum_q;
      rsp_q.secondary_sum <= ssum_q;
    end
  end

  assign status_o.clear_done = !cnt_busy;
  assign status_o.scan_done  = (!cnt_busy || found_q) && !rd_vld_q;
  assign out_rsp_o           = rsp_q;

endmodule

@@ hw/rtl/ttl_slot_pool_with_owner_sums_top.sv @@
// Slot pool with per-slot ttl ageing and per-owner sums: top level.
// Depends on tsp_pkg, tsp_ctrl, tsp_datapath and tsp_ram.
//
// A pool of SLOT_COUNT slots held in one RAM, one word per slot. Every
// request walks the RAM one slot per cycle through its single read port and
// single write port; a register stops the scan at the first free slot it finds.
// Requests are taken one at a time; a finished result waits in the output
// register while the next request is accepted. After reset a clearing pass
// writes every slot to zero, during which in_stall_o stays high.
module ttl_slot_pool_with_owner_sums_top import tsp_pkg::*; #(
  parameter int SLOT_COUNT = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tsp_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tsp_rsp_t out_rsp_o
);

  tsp_ctrl_t   ctrl;
  tsp_status_t status;

  tsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  tsp_datapath #(
    .SlotCount(SLOT_COUNT)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_o (status),
    .in_req_i (in_req_i),
    .out_rsp_o(out_rsp_o)
  );

endmodule

@@ verif/ttl_slot_pool_with_owner_sums_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ttl_slot_pool_with_owner_sums_top: directed and random requests,
// results checked in order against a behavioral slot pool. Depends on tsp_pkg and the RTL.
module ttl_slot_pool_with_owner_sums_top_tb;
  import tsp_pkg::*;

  localparam int SLOT_COUNT = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_REQS = 1550;
  localparam int IDLE_PCT = 31;
  localparam int REPORT_MAX = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 3);
  localparam int WRAP_TICKS = 130;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  tsp_req_t in_req_i;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tsp_rsp_t out_rsp_o;

  // behavioral copy of the pool
  logic [7:0]  pool_ttl       [SLOT_COUNT];
  logic [31:0] pool_owner     [SLOT_COUNT];
  logic [31:0] pool_primary   [SLOT_COUNT];
  logic [31:0] pool_secondary [SLOT_COUNT];
  logic [7:0]  pool_label     [SLOT_COUNT];

  tsp_rsp_t pending_rsp[$];
  tsp_rsp_t rsp_want;
  int       fail_count = 0;
  int       req_count = 0;
  int       quiet_cycles = 0;
  bit       no_idle = 1'b0;

  ttl_slot_pool_with_owner_sums_top #(
    .SLOT_COUNT(SLOT_COUNT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one request to the pool copy and returns the result it gives.
  function automatic tsp_rsp_t pool_apply(input tsp_req_t r);
    tsp_rsp_t    rsp;
    logic [7:0]  t;
    logic [31:0] psum;
    logic [31:0] ssum;
    int          hit;
    rsp  = '0;
    hit  = -1;
    psum = '0;
    ssum = '0;
    case (r.cmd)
      CMD_REGISTER: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (hit < 0 && pool_primary[i] == '0 && pool_secondary[i] == '0 &&
              pool_label[i] == '0) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          pool_ttl[hit]       = TTL_START;
          pool_owner[hit]     = r.owner_key;
          pool_primary[hit]   = r.primary_value;
          pool_secondary[hit] = r.secondary_value;
          pool_label[hit]     = r.label_first_byte;
          rsp.slot_index      = hit[5:0];
        end else begin
          rsp.pool_full = 1'b1;
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          t = pool_ttl[i] - 8'd1;
          pool_ttl[i] = t;
          // signed ttl at or below zero expires the slot
          if (t == 8'd0 || t[7]) begin
            pool_primary[i]   = '0;
            pool_secondary[i] = '0;
            pool_label[i]     = '0;
          end
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (pool_owner[i] == r.owner_key) begin
            if (pool_primary[i] != '0) psum = psum + pool_primary[i];
            if (pool_secondary[i] != '0) ssum = ssum + pool_secondary[i];
          end
        end
        rsp.primary_sum   = psum;
        rsp.secondary_sum = ssum;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic tsp_req_t mk_req(input logic [1:0] cmd, input logic [31:0] owner,
                                      input logic [31:0] prim, input logic [31:0] sec,
                                      input logic [7:0] label);
    tsp_req_t r;
    r.cmd              = cmd;
    r.owner_key        = owner;
    r.primary_value    = prim;
    r.secondary_value  = sec;
    r.label_first_byte = label;
    return r;
  endfunction

  // small key set so that queries hit registered owners often
  function automatic logic [31:0] pick_owner();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h0000_0001;
      5: return 32'h0000_1234;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_amount();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 32'h0;
    if (r < 30) return 32'h7FFF_FFFF;
    if (r < 35) return 32'h8000_0000;
    if (r < 40) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic tsp_req_t random_req(input int tick_pct);
    tsp_req_t r;
    int       sel;
    r = mk_req(CMD_REGISTER, pick_owner(), pick_amount(), pick_amount(),
               ($urandom_range(99) < 25) ? 8'd0 : 8'($urandom_range(1, 255)));
    if ($urandom_range(99) < 5) begin
      r.primary_value    = '0;
      r.secondary_value  = '0;
      r.label_first_byte = '0;
    end
    sel = $urandom_range(99);
    if ($urandom_range(99) < tick_pct) r.cmd = CMD_TICK;
    else if (sel < 5) r.cmd = CMD_UNUSED;
    else if (sel < 40) r.cmd = CMD_QUERY;
    return r;
  endfunction

  // Called just after a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input tsp_req_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rsp.push_back(pool_apply(r));
    req_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_empty_pool();
    send_req(mk_req(CMD_QUERY, 32'h0, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_UNUSED, '1, '1, '1, '1));
    send_req(mk_req(CMD_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_QUERY, 32'h7FFF_FFFF, '1, '1, '1));
  endtask

  task automatic test_register_extremes();
    send_req(mk_req(CMD_REGISTER, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF));
    send_req(mk_req(CMD_REGISTER, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 8'h00));
    // label alone keeps the slot occupied
    send_req(mk_req(CMD_REGISTER, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h01));
    // all-zero data: slot is taken but stays free for the next register
    send_req(mk_req(CMD_REGISTER, 32'h0000_1234, 32'h0, 32'h0, 8'h00));
    send_req(mk_req(CMD_REGISTER, 32'h0000_1234, 32'h1, 32'h0, 8'h00));
    send_req(mk_req(CMD_REGISTER, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, 8'h80));
    send_req(mk_req(CMD_QUERY, 32'h8000_0000, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_QUERY, 32'h7FFF_FFFF, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_QUERY, 32'h0000_1234, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_QUERY, 32'h0, '1, '1, '1));
    send_req(mk_req(CMD_UNUSED, $urandom, $urandom, $urandom, 8'($urandom)));
  endtask

  task automatic test_ageing();
    send_req(mk_req(CMD_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_QUERY, 32'h8000_0000, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_REGISTER, 32'h8000_0000, 32'h5, 32'h6, 8'h07));
    send_req(mk_req(CMD_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    // expired slots keep their owner but add nothing
    send_req(mk_req(CMD_QUERY, 32'h8000_0000, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_REGISTER, 32'h0, 32'h9, 32'h0, 8'h00));
    send_req(mk_req(CMD_QUERY, 32'h0, 32'h0, 32'h0, 8'h0));
  endtask

  task automatic test_pool_full();
    send_req(mk_req(CMD_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    for (int i = 0; i < SLOT_COUNT + 3; i++) begin
      send_req(mk_req(CMD_REGISTER, pick_owner(), pick_amount(), pick_amount(),
                      8'($urandom_range(1, 255))));
    end
    for (int i = 0; i < 4; i++) begin
      send_req(mk_req(CMD_QUERY, pick_owner(), 32'h0, 32'h0, 8'h0));
    end
    // hold the sender until the pool has answered everything
    wait_drained();
    send_req(mk_req(CMD_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    send_req(mk_req(CMD_REGISTER, 32'h1, 32'h2, 32'h3, 8'h4));
  endtask

  // ttl walks through 0xFF down past 0x80 -> 0x7F
  task automatic test_ttl_wrap();
    for (int i = 0; i < 3; i++) begin
      send_req(mk_req(CMD_REGISTER, 32'h1, $urandom, $urandom, 8'($urandom_range(1, 255))));
    end
    for (int i = 0; i < WRAP_TICKS; i++) begin
      send_req(mk_req(CMD_TICK, $urandom, $urandom, $urandom, 8'($urandom)));
      if (i % 32 == 31) send_req(mk_req(CMD_QUERY, 32'h1, 32'h0, 32'h0, 8'h0));
    end
    send_req(mk_req(CMD_REGISTER, 32'h1, 32'h10, 32'h20, 8'h30));
    send_req(mk_req(CMD_QUERY, 32'h1, 32'h0, 32'h0, 8'h0));
  endtask

  // segments with varying tick rates: low rates fill the pool, high rates drain it
  task automatic test_random();
    int seg_len;
    int tick_pct;
    int seg;
    seg = 0;
    while (req_count < TOTAL_REQS) begin
      case ($urandom_range(4))
        0: tick_pct = 0;
        1: tick_pct = 1;
        2: tick_pct = 5;
        3: tick_pct = 15;
        default: tick_pct = 40;
      endcase
      seg_len = $urandom_range(60, 200);
      no_idle = (seg == 1);
      for (int i = 0; i < seg_len && req_count < TOTAL_REQS; i++) begin
        send_req(random_req(tick_pct));
      end
      seg++;
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("unexpected result: idx=%0d full=%0b psum=%h ssum=%h",
                   out_rsp_o.slot_index, out_rsp_o.pool_full,
                   out_rsp_o.primary_sum, out_rsp_o.secondary_sum);
        end
      end else begin
        rsp_want = pending_rsp.pop_front();
        if (out_rsp_o.slot_index !== rsp_want.slot_index ||
            out_rsp_o.pool_full !== rsp_want.pool_full ||
            out_rsp_o.primary_sum !== rsp_want.primary_sum ||
            out_rsp_o.secondary_sum !== rsp_want.secondary_sum) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("mismatch: exp idx=%0d full=%0b psum=%h ssum=%h",
                     rsp_want.slot_index, rsp_want.pool_full,
                     rsp_want.primary_sum, rsp_want.secondary_sum);
            $display("          got idx=%0d full=%0b psum=%h ssum=%h",
                     out_rsp_o.slot_index, out_rsp_o.pool_full,
                     out_rsp_o.primary_sum, out_rsp_o.secondary_sum);
          end
        end
      end
    end
  end

  // watchdog: cycles without any handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_ttl[i]       = '0;
      pool_owner[i]     = '0;
      pool_primary[i]   = '0;
      pool_secondary[i] = '0;
      pool_label[i]     = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_pool();
    test_register_extremes();
    test_ageing();
    test_pool_full();
    test_ttl_wrap();
    test_random();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_rsp.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", pending_rsp.size());
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
